### hdl/cie_pkg.sv
package cie_pkg;

    // Instruction codes as they arrive on the command channel
    typedef enum logic [5:0] {
        OP_ADC     = 6'd0,
        OP_AND     = 6'd1,
        OP_ASL_A   = 6'd2,
        OP_ASL_M   = 6'd3,
        OP_BCC     = 6'd4,
        OP_BCS     = 6'd5,
        OP_BEQ     = 6'd6,
        OP_BIT     = 6'd7,
        OP_BMI     = 6'd8,
        OP_BNE     = 6'd9,
        OP_BPL     = 6'd10,
        OP_BVC     = 6'd11,
        OP_BVS     = 6'd12,
        OP_CLC     = 6'd13,
        OP_CLD     = 6'd14,
        OP_CLI     = 6'd15,
        OP_CLV     = 6'd16,
        OP_CMP     = 6'd17,
        OP_CPX     = 6'd18,
        OP_CPY     = 6'd19,
        OP_DEC_M   = 6'd20,
        OP_DEX     = 6'd21,
        OP_DEY     = 6'd22,
        OP_EOR     = 6'd23,
        OP_INC_M   = 6'd24,
        OP_INX     = 6'd25,
        OP_INY     = 6'd26,
        OP_JMP     = 6'd27,
        OP_LDA     = 6'd28,
        OP_LDX     = 6'd29,
        OP_LDY     = 6'd30,
        OP_LSR_A   = 6'd31,
        OP_LSR_M   = 6'd32,
        OP_NOP     = 6'd33,
        OP_ORA     = 6'd34,
        OP_ROL_A   = 6'd35,
        OP_ROL_M   = 6'd36,
        OP_ROR_A   = 6'd37,
        OP_ROR_M   = 6'd38,
        OP_SBC     = 6'd39,
        OP_SEC     = 6'd40,
        OP_SED     = 6'd41,
        OP_SEI     = 6'd42,
        OP_STA     = 6'd43,
        OP_STX     = 6'd44,
        OP_STY     = 6'd45,
        OP_TAX     = 6'd46,
        OP_TAY     = 6'd47,
        OP_TSX     = 6'd48,
        OP_TXA     = 6'd49,
        OP_TXS     = 6'd50,
        OP_TYA     = 6'd51
    } opcode_t;

    // Execution unit that carries out a decoded word
    typedef enum logic [3:0] {
        U_NOP    = 4'd0,
        U_ADD    = 4'd1,
        U_LOGIC  = 4'd2,
        U_SHIFT  = 4'd3,
        U_BIT    = 4'd4,
        U_BRANCH = 4'd5,
        U_FLAG   = 4'd6,
        U_CMP    = 4'd7,
        U_STEP   = 4'd8,
        U_JMP    = 4'd9,
        U_MOVE   = 4'd10,
        U_STORE  = 4'd11,
        U_TXS    = 4'd12
    } unit_t;

    typedef enum logic [2:0] {
        SRC_A  = 3'd0,
        SRC_X  = 3'd1,
        SRC_Y  = 3'd2,
        SRC_SP = 3'd3,
        SRC_M  = 3'd4
    } src_t;

    typedef enum logic [1:0] {
        DST_A   = 2'd0,
        DST_X   = 2'd1,
        DST_Y   = 2'd2,
        DST_MEM = 2'd3
    } dst_t;

    // Sub-operation codes, meaning depends on the unit
    localparam logic [1:0] ADD_PLAIN  = 2'd0;
    localparam logic [1:0] ADD_INVERT = 2'd1;
    localparam logic [1:0] LOG_AND    = 2'd0;
    localparam logic [1:0] LOG_ORA    = 2'd1;
    localparam logic [1:0] LOG_EOR    = 2'd2;
    localparam logic [1:0] SH_ASL     = 2'd0;
    localparam logic [1:0] SH_LSR     = 2'd1;
    localparam logic [1:0] SH_ROL     = 2'd2;
    localparam logic [1:0] SH_ROR     = 2'd3;
    localparam logic [1:0] STEP_INC   = 2'd0;
    localparam logic [1:0] STEP_DEC   = 2'd1;

    // Bit positions in the status byte
    localparam logic [2:0] FLAG_C = 3'd0;
    localparam logic [2:0] FLAG_Z = 3'd1;
    localparam logic [2:0] FLAG_I = 3'd2;
    localparam logic [2:0] FLAG_D = 3'd3;
    localparam logic [2:0] FLAG_B = 3'd4;
    localparam logic [2:0] FLAG_U = 3'd5;
    localparam logic [2:0] FLAG_V = 3'd6;
    localparam logic [2:0] FLAG_N = 3'd7;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    typedef struct packed {
        logic [5:0]  operation;
        logic [7:0]  operand;
        logic [15:0] address;
        logic [15:0] next_pc;
    } command_t;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  status_out;
        logic [15:0] new_pc;
        logic        mem_write;
        logic [15:0] write_address;
        logic [7:0]  write_data;
    } result_t;

    typedef struct packed {
        unit_t      unit;
        src_t       src;
        dst_t       dst;
        logic [1:0] sub;
        logic [2:0] flag;
        logic       sense;
    } ctl_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [7:0]  operand;
        logic [15:0] address;
        logic [15:0] next_pc;
    } exec_t;

endpackage

### hdl/cpu8_instruction_execute_unit.sv
// Execute stage of an 8-bit accumulator machine.
//
// Command channel: drive a decoded instruction word on command and raise push;
// the word is taken at a rising edge with push high and full low.
// Result channel: while empty is low, result carries the oldest finished word
// (registers, status, next program counter and any memory write); raise pop to
// take it at a rising edge where empty is low.
//
// Throughput: one instruction per cycle while a word is queued and the result
// queue has room; the A, X, Y, SP and status registers of the execute stage
// feed back into the next instruction. A taken word waits in the command
// queue, is executed into the result queue and waits there until popped.
//
// Reset clears both queues and loads A = X = Y = 0, SP = 0xFD, status = 0x24.
// When the receiver stalls, the result queue fills, execution holds and the
// command queue then fills and raises full; no word is lost or repeated.
module cpu8_instruction_execute_unit #(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cie_pkg::command_t command,
    output logic              empty,
    input  logic              pop,
    output cie_pkg::result_t  result
);

    logic           q_empty;
    logic           q_take;
    cie_pkg::exec_t q_word;

    // Front end: classify and queue incoming words
    cie_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .command (command),
        .take    (q_take),
        .empty   (q_empty),
        .word    (q_word)
    );

    // Back end: execute against the kept registers and queue results
    cie_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_word  (q_word),
        .q_take  (q_take),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### hdl/cie_fifo.sv
module cie_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fifo count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("fifo count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> count_reg == $past(count_reg) - CW'(1))
        else $error("fifo count missed a pop");

endmodule

### hdl/cie_front.sv
module cie_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cie_pkg::command_t command,
    input  logic              take,
    output logic              empty,
    output cie_pkg::exec_t    word
);

    cie_pkg::ctl_t  ctl;
    cie_pkg::exec_t dec_word;

    // Classify the instruction into unit, operand routing and flag selection
    always_comb
    begin
        ctl.unit  = cie_pkg::U_NOP;
        ctl.src   = cie_pkg::SRC_M;
        ctl.dst   = cie_pkg::DST_A;
        ctl.sub   = 2'd0;
        ctl.flag  = cie_pkg::FLAG_C;
        ctl.sense = 1'b0;
        case (cie_pkg::opcode_t'(command.operation))
            cie_pkg::OP_ADC:
            begin
                ctl.unit = cie_pkg::U_ADD;
                ctl.sub  = cie_pkg::ADD_PLAIN;
            end
            cie_pkg::OP_SBC:
            begin
                ctl.unit = cie_pkg::U_ADD;
                ctl.sub  = cie_pkg::ADD_INVERT;
            end
            cie_pkg::OP_AND:
            begin
                ctl.unit = cie_pkg::U_LOGIC;
                ctl.sub  = cie_pkg::LOG_AND;
            end
            cie_pkg::OP_ORA:
            begin
                ctl.unit = cie_pkg::U_LOGIC;
                ctl.sub  = cie_pkg::LOG_ORA;
            end
            cie_pkg::OP_EOR:
            begin
                ctl.unit = cie_pkg::U_LOGIC;
                ctl.sub  = cie_pkg::LOG_EOR;
            end
            cie_pkg::OP_ASL_A, cie_pkg::OP_LSR_A, cie_pkg::OP_ROL_A, cie_pkg::OP_ROR_A:
            begin
                ctl.unit = cie_pkg::U_SHIFT;
                ctl.src  = cie_pkg::SRC_A;
                ctl.dst  = cie_pkg::DST_A;
            end
            cie_pkg::OP_ASL_M, cie_pkg::OP_LSR_M, cie_pkg::OP_ROL_M, cie_pkg::OP_ROR_M:
            begin
                ctl.unit = cie_pkg::U_SHIFT;
                ctl.src  = cie_pkg::SRC_M;
                ctl.dst  = cie_pkg::DST_MEM;
            end
            cie_pkg::OP_BCC, cie_pkg::OP_BCS:
            begin
                ctl.unit = cie_pkg::U_BRANCH;
                ctl.flag = cie_pkg::FLAG_C;
            end
            cie_pkg::OP_BEQ, cie_pkg::OP_BNE:
            begin
                ctl.unit = cie_pkg::U_BRANCH;
                ctl.flag = cie_pkg::FLAG_Z;
            end
            cie_pkg::OP_BMI, cie_pkg::OP_BPL:
            begin
                ctl.unit = cie_pkg::U_BRANCH;
                ctl.flag = cie_pkg::FLAG_N;
            end
            cie_pkg::OP_BVC, cie_pkg::OP_BVS:
            begin
                ctl.unit = cie_pkg::U_BRANCH;
                ctl.flag = cie_pkg::FLAG_V;
            end
            cie_pkg::OP_BIT:
            begin
                ctl.unit = cie_pkg::U_BIT;
            end
            cie_pkg::OP_CLC, cie_pkg::OP_SEC:
            begin
                ctl.unit = cie_pkg::U_FLAG;
                ctl.flag = cie_pkg::FLAG_C;
            end
            cie_pkg::OP_CLD, cie_pkg::OP_SED:
            begin
                ctl.unit = cie_pkg::U_FLAG;
                ctl.flag = cie_pkg::FLAG_D;
            end
            cie_pkg::OP_CLI, cie_pkg::OP_SEI:
            begin
                ctl.unit = cie_pkg::U_FLAG;
                ctl.flag = cie_pkg::FLAG_I;
            end
            cie_pkg::OP_CLV:
            begin
                ctl.unit = cie_pkg::U_FLAG;
                ctl.flag = cie_pkg::FLAG_V;
            end
            cie_pkg::OP_CMP:
            begin
                ctl.unit = cie_pkg::U_CMP;
                ctl.src  = cie_pkg::SRC_A;
            end
            cie_pkg::OP_CPX:
            begin
                ctl.unit = cie_pkg::U_CMP;
                ctl.src  = cie_pkg::SRC_X;
            end
            cie_pkg::OP_CPY:
            begin
                ctl.unit = cie_pkg::U_CMP;
                ctl.src  = cie_pkg::SRC_Y;
            end
            cie_pkg::OP_DEC_M, cie_pkg::OP_INC_M:
            begin
                ctl.unit = cie_pkg::U_STEP;
                ctl.src  = cie_pkg::SRC_M;
                ctl.dst  = cie_pkg::DST_MEM;
            end
            cie_pkg::OP_DEX, cie_pkg::OP_INX:
            begin
                ctl.unit = cie_pkg::U_STEP;
                ctl.src  = cie_pkg::SRC_X;
                ctl.dst  = cie_pkg::DST_X;
            end
            cie_pkg::OP_DEY, cie_pkg::OP_INY:
            begin
                ctl.unit = cie_pkg::U_STEP;
                ctl.src  = cie_pkg::SRC_Y;
                ctl.dst  = cie_pkg::DST_Y;
            end
            cie_pkg::OP_JMP:
            begin
                ctl.unit = cie_pkg::U_JMP;
            end
            cie_pkg::OP_LDA:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.dst  = cie_pkg::DST_A;
            end
            cie_pkg::OP_LDX:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.dst  = cie_pkg::DST_X;
            end
            cie_pkg::OP_LDY:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.dst  = cie_pkg::DST_Y;
            end
            cie_pkg::OP_TAX:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.src  = cie_pkg::SRC_A;
                ctl.dst  = cie_pkg::DST_X;
            end
            cie_pkg::OP_TAY:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.src  = cie_pkg::SRC_A;
                ctl.dst  = cie_pkg::DST_Y;
            end
            cie_pkg::OP_TSX:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.src  = cie_pkg::SRC_SP;
                ctl.dst  = cie_pkg::DST_X;
            end
            cie_pkg::OP_TXA:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.src  = cie_pkg::SRC_X;
                ctl.dst  = cie_pkg::DST_A;
            end
            cie_pkg::OP_TYA:
            begin
                ctl.unit = cie_pkg::U_MOVE;
                ctl.src  = cie_pkg::SRC_Y;
                ctl.dst  = cie_pkg::DST_A;
            end
            cie_pkg::OP_STA:
            begin
                ctl.unit = cie_pkg::U_STORE;
                ctl.src  = cie_pkg::SRC_A;
            end
            cie_pkg::OP_STX:
            begin
                ctl.unit = cie_pkg::U_STORE;
                ctl.src  = cie_pkg::SRC_X;
            end
            cie_pkg::OP_STY:
            begin
                ctl.unit = cie_pkg::U_STORE;
                ctl.src  = cie_pkg::SRC_Y;
            end
            cie_pkg::OP_TXS:
            begin
                ctl.unit = cie_pkg::U_TXS;
            end
            default:
            begin
                ctl.unit = cie_pkg::U_NOP;
            end
        endcase

        // Shift kind, step direction and branch or flag polarity
        case (cie_pkg::opcode_t'(command.operation))
            cie_pkg::OP_ASL_A, cie_pkg::OP_ASL_M: ctl.sub = cie_pkg::SH_ASL;
            cie_pkg::OP_LSR_A, cie_pkg::OP_LSR_M: ctl.sub = cie_pkg::SH_LSR;
            cie_pkg::OP_ROL_A, cie_pkg::OP_ROL_M: ctl.sub = cie_pkg::SH_ROL;
            cie_pkg::OP_ROR_A, cie_pkg::OP_ROR_M: ctl.sub = cie_pkg::SH_ROR;
            cie_pkg::OP_INC_M, cie_pkg::OP_INX, cie_pkg::OP_INY: ctl.sub = cie_pkg::STEP_INC;
            cie_pkg::OP_DEC_M, cie_pkg::OP_DEX, cie_pkg::OP_DEY: ctl.sub = cie_pkg::STEP_DEC;
            cie_pkg::OP_BCS, cie_pkg::OP_BEQ, cie_pkg::OP_BMI, cie_pkg::OP_BVS,
            cie_pkg::OP_SEC, cie_pkg::OP_SED, cie_pkg::OP_SEI: ctl.sense = 1'b1;
            default: ;
        endcase
    end

    assign dec_word.ctl     = ctl;
    assign dec_word.operand = command.operand;
    assign dec_word.address = command.address;
    assign dec_word.next_pc = command.next_pc;

    // Hold decoded words until the back end takes them
    cie_fifo #(
        .WIDTH ($bits(cie_pkg::exec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (dec_word),
        .pop   (take),
        .empty (empty),
        .rdata (word)
    );

endmodule

### hdl/cie_back.sv
module cie_back #(
    parameter int RESULT_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cie_pkg::exec_t    q_word,
    output logic              q_take,
    output logic              empty,
    input  logic              pop,
    output cie_pkg::result_t  result
);

    logic [7:0]       a_reg, a_next;
    logic [7:0]       x_reg, x_next;
    logic [7:0]       y_reg, y_next;
    logic [7:0]       sp_reg, sp_next;
    logic [7:0]       p_reg, p_next;
    logic             res_full;
    logic             fire;
    cie_pkg::result_t res_word;

    logic [7:0]  src_val;
    logic [7:0]  res8;
    logic [7:0]  mop;
    logic [8:0]  sum9;
    logic        put;
    logic        wr;
    logic [7:0]  wdata;
    logic [15:0] npc;

    function automatic logic [7:0] zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q                 = p;
        q[cie_pkg::FLAG_Z] = (v == 8'h00);
        q[cie_pkg::FLAG_N] = v[7];
        return q;
    endfunction

    assign fire   = !q_empty && !res_full;
    assign q_take = fire;

    always_comb
    begin
        case (q_word.ctl.src)
            cie_pkg::SRC_A:  src_val = a_reg;
            cie_pkg::SRC_X:  src_val = x_reg;
            cie_pkg::SRC_Y:  src_val = y_reg;
            cie_pkg::SRC_SP: src_val = sp_reg;
            default:         src_val = q_word.operand;
        endcase
    end

    always_comb
    begin
        a_next  = a_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        sp_next = sp_reg;
        p_next  = p_reg;
        npc     = q_word.next_pc;
        res8    = 8'h00;
        mop     = q_word.operand;
        sum9    = 9'h000;
        put     = 1'b0;
        wr      = 1'b0;
        wdata   = 8'h00;
        case (q_word.ctl.unit)
            cie_pkg::U_ADD:
            begin
                // Subtract is add of the inverted operand with carry as inverted borrow
                mop  = (q_word.ctl.sub == cie_pkg::ADD_INVERT) ? ~q_word.operand
                                                               : q_word.operand;
                sum9 = {1'b0, a_reg} + {1'b0, mop} + {8'h00, p_reg[cie_pkg::FLAG_C]};
                res8 = sum9[7:0];
                p_next[cie_pkg::FLAG_C] = sum9[8];
                p_next[cie_pkg::FLAG_V] = ~(a_reg[7] ^ mop[7]) & (a_reg[7] ^ res8[7]);
                put  = 1'b1;
            end
            cie_pkg::U_LOGIC:
            begin
                case (q_word.ctl.sub)
                    cie_pkg::LOG_AND: res8 = a_reg & q_word.operand;
                    cie_pkg::LOG_ORA: res8 = a_reg | q_word.operand;
                    default:          res8 = a_reg ^ q_word.operand;
                endcase
                put = 1'b1;
            end
            cie_pkg::U_SHIFT:
            begin
                case (q_word.ctl.sub)
                    cie_pkg::SH_ASL:
                    begin
                        p_next[cie_pkg::FLAG_C] = src_val[7];
                        res8 = {src_val[6:0], 1'b0};
                    end
                    cie_pkg::SH_LSR:
                    begin
                        p_next[cie_pkg::FLAG_C] = src_val[0];
                        res8 = {1'b0, src_val[7:1]};
                    end
                    cie_pkg::SH_ROL:
                    begin
                        p_next[cie_pkg::FLAG_C] = src_val[7];
                        res8 = {src_val[6:0], p_reg[cie_pkg::FLAG_C]};
                    end
                    default:
                    begin
                        p_next[cie_pkg::FLAG_C] = src_val[0];
                        res8 = {p_reg[cie_pkg::FLAG_C], src_val[7:1]};
                    end
                endcase
                put = 1'b1;
            end
            cie_pkg::U_BIT:
            begin
                p_next[cie_pkg::FLAG_Z] = ((a_reg & q_word.operand) == 8'h00);
                p_next[cie_pkg::FLAG_N] = q_word.operand[7];
                p_next[cie_pkg::FLAG_V] = q_word.operand[6];
            end
            cie_pkg::U_BRANCH:
            begin
                if (p_reg[q_word.ctl.flag] == q_word.ctl.sense)
                begin
                    npc = q_word.next_pc + {{8{q_word.operand[7]}}, q_word.operand};
                end
            end
            cie_pkg::U_FLAG:
            begin
                p_next[q_word.ctl.flag] = q_word.ctl.sense;
            end
            cie_pkg::U_CMP:
            begin
                p_next[cie_pkg::FLAG_C] = (src_val >= q_word.operand);
                p_next = zn(p_next, src_val - q_word.operand);
            end
            cie_pkg::U_STEP:
            begin
                res8 = (q_word.ctl.sub == cie_pkg::STEP_DEC) ? src_val - 8'h01
                                                            : src_val + 8'h01;
                put  = 1'b1;
            end
            cie_pkg::U_JMP:
            begin
                npc = q_word.address;
            end
            cie_pkg::U_MOVE:
            begin
                res8 = src_val;
                put  = 1'b1;
            end
            cie_pkg::U_STORE:
            begin
                wr    = 1'b1;
                wdata = src_val;
            end
            cie_pkg::U_TXS:
            begin
                sp_next = x_reg;
            end
            default: ;
        endcase

        // Route the ALU byte to its destination and update Z and N
        if (put)
        begin
            p_next = zn(p_next, res8);
            case (q_word.ctl.dst)
                cie_pkg::DST_A: a_next = res8;
                cie_pkg::DST_X: x_next = res8;
                cie_pkg::DST_Y: y_next = res8;
                default:
                begin
                    wr    = 1'b1;
                    wdata = res8;
                end
            endcase
        end
    end

    assign res_word.acc_out       = a_next;
    assign res_word.x_out         = x_next;
    assign res_word.y_out         = y_next;
    assign res_word.sp_out        = sp_next;
    assign res_word.status_out    = p_next;
    assign res_word.new_pc        = npc;
    assign res_word.mem_write     = wr;
    assign res_word.write_address = wr ? q_word.address : 16'h0000;
    assign res_word.write_data    = wr ? wdata : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= 8'h00;
            x_reg  <= 8'h00;
            y_reg  <= 8'h00;
            sp_reg <= cie_pkg::SP_RESET;
            p_reg  <= cie_pkg::STATUS_RESET;
        end
        else if (fire)
        begin
            a_reg  <= a_next;
            x_reg  <= x_next;
            y_reg  <= y_next;
            sp_reg <= sp_next;
            p_reg  <= p_next;
        end
    end

    // Result queue parts the execute stage from the receiver
    cie_fifo #(
        .WIDTH ($bits(cie_pkg::result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .full  (res_full),
        .wdata (res_word),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

    a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg[cie_pkg::FLAG_U] && !p_reg[cie_pkg::FLAG_B])
        else $error("constant status bits changed");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable({a_reg, x_reg, y_reg, sp_reg, p_reg}))
        else $error("architectural state moved without an instruction");

    a_sp_only_txs: assert property (@(posedge clk) disable iff (!rst_n)
        fire && q_word.ctl.unit != cie_pkg::U_TXS |=> sp_reg == $past(sp_reg))
        else $error("stack pointer changed outside TXS");

endmodule
